>>> hdl/bspl_pkg.sv
// Shared types and constants for the partition tree point locator.
`timescale 1ns / 1ps

package bspl_pkg;

  localparam int MAX_NODES  = 8192;
  localparam int MAX_LEAVES = 32768;
  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int COUNT_W    = NODE_AW + 1;
  localparam int LEAF_W     = $clog2(MAX_LEAVES);
  localparam int FRAC_SHIFT = 16;
  localparam int NODE_W     = 160;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] WALK_OK    = 2'd0;
  localparam logic [1:0] WALK_LONG  = 2'd1;
  localparam logic [1:0] WALK_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL0,
    ST_MUL1,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic               mode;
    logic [12:0]        node_index;
    logic signed [31:0] line_x;
    logic signed [31:0] line_y;
    logic signed [31:0] line_dx;
    logic signed [31:0] line_dy;
    logic [14:0]        child0_index;
    logic               child0_leaf;
    logic [14:0]        child1_index;
    logic               child1_leaf;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
  } request_t;

  typedef struct packed {
    logic [14:0] subsector_index;
    logic [13:0] walk_steps;
    logic [1:0]  walk_error;
  } result_t;

  typedef struct packed {
    logic        leaf;
    logic [14:0] index;
  } child_t;

  typedef struct packed {
    logic signed [31:0] oy;
    logic signed [31:0] ox;
    logic signed [31:0] dy;
    logic signed [31:0] dx;
    child_t             c1;
    child_t             c0;
  } node_t;

endpackage

>>> hdl/bsp_point_locate.sv
// Top level of the partition tree point locator: node store, sequencer and cross unit.
`timescale 1ns / 1ps

// The block holds up to 8192 partition nodes in one on-chip RAM and walks them
// to find the leaf that contains a query point.
// A request is taken when start is high and busy is low. A write request
// (mode low) stores one node in the same cycle and leaves the block ready;
// it gives no result. A query request (mode high) raises busy while the tree
// is walked from the root, node node_count minus one.
// Each tree level is one RAM read (ST_FETCH), two passes through the
// single shared 33 by 32 bit multiplier (ST_MUL0, ST_MUL1), and one subtract
// that picks a child (ST_DECIDE). A walk that would visit more than
// node_count nodes is stopped with WALK_LONG. An empty tree or an oversized
// node count is answered from idle without a walk.
// The answer sits on result for exactly one cycle with done high; the
// receiver cannot stall it, and a new request may be taken in that cycle.
// The cfg channel writes node_count and is always ready; the user must write it
// only while no query is in progress, since the block does not enforce it.
// Reset clears node_count, the sequencer and the strobe; the node RAM is not
// cleared and a node must be written before a query reaches it.
module bsp_point_locate
  import bspl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  request_t      request,
  output logic          done,
  output result_t       result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [13:0]   cfg_data
);

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0]  node_count;
  logic [NODE_AW-1:0]  cur;
  logic [COUNT_W-1:0]  steps;
  logic signed [31:0]  px;
  logic signed [31:0]  py;
  logic signed [64:0]  prod0;
  logic signed [64:0]  prod1;

  logic                accept;
  logic                ram_we;
  logic                ram_re;
  logic [NODE_W-1:0]   ram_rdata;
  node_t               node;
  node_t               wr_node;

  logic signed [32:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [64:0]  mul_p;
  logic signed [65:0]  diff;
  child_t              pick;
  logic                walk_long;
  logic                count_big;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign node      = node_t'(ram_rdata);

  always_comb begin
    wr_node.ox = request.line_x;
    wr_node.oy = request.line_y;
    wr_node.dx = request.line_dx;
    wr_node.dy = request.line_dy;
    wr_node.c0 = '{leaf: request.child0_leaf, index: request.child0_index};
    wr_node.c1 = '{leaf: request.child1_leaf, index: request.child1_index};
  end

  bspl_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (request.node_index),
    .wdata (NODE_W'(wr_node)),
    .re    (ram_re),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  assign count_big = (node_count > COUNT_W'(MAX_NODES));
  assign walk_long = (steps >= node_count);
  assign mul_p     = mul_a * mul_b;
  assign diff      = {prod0[64], prod0} - {prod1[64], prod1};
  assign pick      = diff[65] ? node.c0 : node.c1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && request.mode == MODE_QUERY && node_count != '0 && !count_big) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = walk_long ? ST_IDLE : ST_MUL0;
      end
      ST_MUL0: begin
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (pick.leaf || pick.index >= LEAF_W'(node_count)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_IDLE: begin
        ram_we = accept && request.mode == MODE_WRITE;
      end
      ST_FETCH: begin
        ram_re = !walk_long;
      end
      ST_MUL0: begin
        mul_a = {node.ox[31], node.ox} - {px[31], px};
        mul_b = node.dy;
      end
      ST_MUL1: begin
        mul_a = {node.oy[31], node.oy} - {py[31], py};
        mul_b = node.dx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept && request.mode == MODE_QUERY) begin
            if (node_count == '0) begin
              done   <= 1'b1;
              result <= '{subsector_index: '0, walk_steps: '0, walk_error: WALK_OK};
            end else if (count_big) begin
              done   <= 1'b1;
              result <= '{subsector_index: '0, walk_steps: '0, walk_error: WALK_RANGE};
            end
          end
        end
        ST_FETCH: begin
          if (walk_long) begin
            done   <= 1'b1;
            result <= '{subsector_index: '0, walk_steps: steps, walk_error: WALK_LONG};
          end
        end
        ST_DECIDE: begin
          if (pick.leaf) begin
            done   <= 1'b1;
            result <= '{subsector_index: pick.index, walk_steps: steps, walk_error: WALK_OK};
          end else if (pick.index >= LEAF_W'(node_count)) begin
            done   <= 1'b1;
            result <= '{subsector_index: '0, walk_steps: steps, walk_error: WALK_RANGE};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          px    <= {request.query_x, 16'b0};
          py    <= {request.query_y, 16'b0};
          steps <= '0;
          cur   <= NODE_AW'(node_count - 1'b1);
        end
      end
      ST_FETCH: begin
        if (!walk_long) begin
          steps <= steps + 1'b1;
        end
      end
      ST_MUL0: begin
        prod0 <= mul_p;
      end
      ST_MUL1: begin
        prod1 <= mul_p;
      end
      ST_DECIDE: begin
        cur <= pick.index[NODE_AW-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/bspl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bspl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sim/bsp_point_locate_tb.sv
// Self-checking testbench for the partition tree point locator, with a directed table and random phases.
`timescale 1ns / 1ps

module bsp_point_locate_tb;
  import bspl_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int ITEM_TARGET    = 1650;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic {ROW_COUNT, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [13:0] count;
    request_t    rq;
    bit          typed;
    result_t     answer;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  request_t    request = '0;
  logic        done;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data = '0;

  request_t    node_mem [MAX_NODES];
  bit          node_written [MAX_NODES];
  logic [13:0] node_count_q = '0;
  result_t     expected_answers [$];
  step_row_t   directed_rows [$];
  result_t     want_q;
  int          mismatches = 0;
  int          sent_items = 0;
  int          idle_cycles = 0;

  bsp_point_locate u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Walks the mirrored node table; clean drops when the walk would read a slot never written.
  function automatic result_t locate_leaf(input request_t rq, output bit clean);
    result_t             res;
    request_t            nd;
    logic [12:0]         cur;
    logic [15:0]         pick;
    logic signed [127:0] ex, ey, cross_z;
    int unsigned         steps;
    bit                  stop;
    res   = '0;
    clean = 1'b1;
    steps = 0;
    stop  = 1'b0;
    res.walk_error = WALK_OK;
    if (node_count_q == 0) begin
      stop = 1'b1;
    end else if (node_count_q > MAX_NODES) begin
      res.walk_error = WALK_RANGE;
      stop = 1'b1;
    end
    cur = 13'(node_count_q - 14'd1);
    while (!stop) begin
      if (steps >= node_count_q) begin
        res.walk_error = WALK_LONG;
        stop = 1'b1;
      end else if (!node_written[cur]) begin
        clean = 1'b0;
        stop  = 1'b1;
      end else begin
        steps++;
        nd      = node_mem[cur];
        ex      = $signed(nd.line_x) - ($signed(rq.query_x) <<< FRAC_SHIFT);
        ey      = $signed(nd.line_y) - ($signed(rq.query_y) <<< FRAC_SHIFT);
        cross_z = ex * $signed(nd.line_dy) - ey * $signed(nd.line_dx);
        pick    = cross_z[127] ? {nd.child0_leaf, nd.child0_index}
                               : {nd.child1_leaf, nd.child1_index};
        if (pick[15]) begin
          res.subsector_index = pick[14:0];
          stop = 1'b1;
        end else if (pick[14:0] >= node_count_q) begin
          res.walk_error = WALK_RANGE;
          stop = 1'b1;
        end else begin
          cur = pick[12:0];
        end
      end
    end
    res.walk_steps = 14'(steps);
    if (res.walk_error != WALK_OK) res.subsector_index = '0;
    return res;
  endfunction

  function automatic request_t random_request();
    logic [255:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(request_t)-1:0];
  endfunction

  // Without loops a node only points further down the written window, so walks stay short.
  function automatic logic [15:0] pick_child(int slot, int count, int base, bit loops);
    int roll;
    roll = $urandom_range(0, 99);
    if (count == 0 || count > MAX_NODES || roll < 45) return {1'b1, 15'($urandom())};
    if (roll < 55) return {1'b0, 15'($urandom_range(count, MAX_LEAVES - 1))};
    if (loops) return {1'b0, 15'($urandom_range(base, count - 1))};
    if (slot > base && slot < count) return {1'b0, 15'($urandom_range(base, slot - 1))};
    return {1'b1, 15'($urandom())};
  endfunction

  function automatic request_t random_node(int slot, int count, int base, bit loops);
    request_t rq;
    rq = random_request();
    rq.mode       = MODE_WRITE;
    rq.node_index = 13'(slot);
    {rq.child0_leaf, rq.child0_index} = pick_child(slot, count, base, loops);
    {rq.child1_leaf, rq.child1_index} = pick_child(slot, count, base, loops);
    return rq;
  endfunction

  function automatic int unsigned idle_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic add_count(input logic [13:0] count);
    step_row_t row;
    row = '{kind: ROW_COUNT, count: count, rq: '0, typed: 1'b0, answer: '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_node(input logic [12:0] slot, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] dx,
                          input logic signed [31:0] dy, input logic [15:0] c0,
                          input logic [15:0] c1);
    step_row_t row;
    row = '{kind: ROW_ITEM, count: '0, rq: '0, typed: 1'b0, answer: '0};
    row.rq.mode       = MODE_WRITE;
    row.rq.node_index = slot;
    row.rq.line_x     = x;
    row.rq.line_y     = y;
    row.rq.line_dx    = dx;
    row.rq.line_dy    = dy;
    {row.rq.child0_leaf, row.rq.child0_index} = c0;
    {row.rq.child1_leaf, row.rq.child1_index} = c1;
    directed_rows.push_back(row);
  endtask

  task automatic add_point(input logic signed [15:0] qx, input logic signed [15:0] qy,
                           input bit typed, input result_t answer);
    step_row_t row;
    row = '{kind: ROW_ITEM, count: '0, rq: '0, typed: typed, answer: answer};
    row.rq.mode    = MODE_QUERY;
    row.rq.query_x = qx;
    row.rq.query_y = qy;
    directed_rows.push_back(row);
  endtask

  task automatic issue(input request_t rq, input int unsigned gap, input bit typed,
                       input result_t answer);
    bit clean;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= rq;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
    if (rq.mode == MODE_WRITE) begin
      node_mem[rq.node_index]     = rq;
      node_written[rq.node_index] = 1'b1;
    end else begin
      expected_answers.push_back(typed ? answer : locate_leaf(rq, clean));
    end
  endtask

  task automatic set_node_count(input logic [13:0] count);
    cfg_data  <= count;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_count_q = count;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Result with no query pending: leaf %0d steps %0d error %0d",
                   result.subsector_index, result.walk_steps, result.walk_error);
      end else begin
        want_q = expected_answers.pop_front();
        if (result.subsector_index !== want_q.subsector_index ||
            result.walk_steps !== want_q.walk_steps ||
            result.walk_error !== want_q.walk_error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected leaf %0d steps %0d error %0d, got %0d %0d %0d",
                     want_q.subsector_index, want_q.walk_steps, want_q.walk_error,
                     result.subsector_index, result.walk_steps, result.walk_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    request_t    rq;
    logic [13:0] n;
    int          base, slot, burst, phase;
    bit          live, loops, quiet, clean;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_count(14'd0);
    add_point(16'sd0, 16'sd0, 1'b1, result_t'{15'd0, 14'd0, WALK_OK});
    add_count(14'd16383);
    add_point(16'sd5, -16'sd5, 1'b1, result_t'{15'd0, 14'd0, WALK_RANGE});
    add_count(14'(MAX_NODES + 1));
    add_point(-16'sd7, 16'sd3, 1'b1, result_t'{15'd0, 14'd0, WALK_RANGE});
    add_count(14'd1);
    add_node(13'd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, {1'b1, 15'd5}, {1'b1, 15'd32767});
    add_point(16'sd0, -16'sd1, 1'b0, '0);
    add_point(16'sd0, 16'sd1, 1'b0, '0);
    add_point(16'sd7, 16'sd0, 1'b0, '0);
    add_point(-16'sd32768, -16'sd32768, 1'b0, '0);
    add_point(16'sd32767, 16'sd32767, 1'b0, '0);
    add_node(13'd0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
             {1'b1, 15'd0}, {1'b1, 15'd32767});
    add_point(16'sd32767, -16'sd32768, 1'b0, '0);
    add_point(-16'sd32768, 16'sd32767, 1'b0, '0);
    add_node(13'd0, 32'sd1000, -32'sd2000, 32'sd0, 32'sd0, {1'b1, 15'd1}, {1'b1, 15'd2});
    add_point(16'sd123, -16'sd45, 1'b0, '0);
    add_count(14'd2);
    add_node(13'd1, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, {1'b0, 15'd2}, {1'b0, 15'd0});
    add_node(13'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, {1'b0, 15'd1}, {1'b0, 15'd1});
    add_point(16'sd0, -16'sd1, 1'b1, result_t'{15'd0, 14'd1, WALK_RANGE});
    add_point(16'sd0, 16'sd1, 1'b1, result_t'{15'd0, 14'd2, WALK_LONG});
    add_count(14'(MAX_NODES));
    add_node(13'd8191, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
             {1'b0, 15'd32767}, {1'b1, 15'd32767});
    add_point(16'sd0, -16'sd1, 1'b1, result_t'{15'd0, 14'd1, WALK_RANGE});
    add_point(16'sd0, 16'sd1, 1'b0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_COUNT) begin
        wait_idle();
        set_node_count(directed_rows[i].count);
      end else begin
        issue(directed_rows[i].rq, $urandom_range(0, 4), directed_rows[i].typed,
              directed_rows[i].answer);
      end
    end

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      if (phase == 2) begin
        n = 14'(MAX_NODES);
      end else if (phase == 6) begin
        n = 14'($urandom_range(65, MAX_NODES - 1));
      end else if (phase % 9 == 4) begin
        n = 14'd0;
      end else if (phase % 9 == 8) begin
        n = 14'($urandom_range(MAX_NODES + 1, 16383));
      end else if ($urandom_range(0, 4) == 0) begin
        n = 14'($urandom_range(13, 32));
      end else begin
        n = 14'($urandom_range(1, 12));
      end
      quiet = ($urandom_range(0, 3) == 0);
      live  = (n != 0 && n <= MAX_NODES);
      loops = (n <= 64);
      base  = (live && !loops) ? int'(n) - 8 : 0;

      wait_idle();
      set_node_count(n);
      if (live) begin
        for (slot = base; slot < int'(n); slot++)
          issue(random_node(slot, n, base, loops), idle_gap(quiet), 1'b0, '0);
      end

      burst = $urandom_range(15, 40);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 20) begin
          slot = (live && $urandom_range(0, 9) < 7) ? $urandom_range(base, int'(n) - 1)
                                                    : $urandom_range(0, MAX_NODES - 1);
          issue(random_node(slot, n, base, loops), idle_gap(quiet), 1'b0, '0);
        end else begin
          rq = random_request();
          rq.mode = MODE_QUERY;
          void'(locate_leaf(rq, clean));
          if (clean) issue(rq, idle_gap(quiet), 1'b0, '0);
        end
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
